/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define IWEB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define IWEB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/iweb_pkg.sv */
// ----------------------------------------------------------------------------
// iweb_pkg
// Shared widths, codes and control types of the eviction buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iweb_pkg;

  // Field widths of the request and response
  localparam int OP_W    = 2;
  localparam int PLD_W   = 32;
  localparam int IMPIN_W = 16;
  localparam int IMP_W   = 15;
  localparam int RIDX_W  = 4;
  localparam int CNTO_W  = 5;

  // Configuration
  localparam int CAP_W      = 5;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 2;
  localparam logic [APB_ADDR_W-1:0] CAP_ADDR  = 2'd0;
  localparam logic [CAP_W-1:0]      CAP_RESET = 5'd16;

  localparam logic [IMP_W-1:0] IMP_MAX = 15'h7fff;

  // Parameter defaults
  localparam int DEF_MAX_ENTRIES  = 16;
  localparam int DEF_PAYLOAD_BITS = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } iweb_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_TAIL,
    ST_SHIFT,
    ST_SHIFT_TAIL,
    ST_APPEND,
    ST_DONE
  } iweb_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;      // latch request fields
    logic pos_clr;     // restart the walk position
    logic issue;       // read store at walk position, advance
    logic proc_scan;   // fold returned word into victim search
    logic proc_shift;  // move returned word down / fold into min, max
    logic acc_init;    // min, max start from the new importance
    logic append;      // write new entry as newest
    logic load_out;    // load output register
  } iweb_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic full;        // count has reached the capacity in use
    logic last_issue;  // walk position is the newest entry
    logic out_free;    // output register can take a result
  } iweb_sts_t;

endpackage

`default_nettype wire

/* rtl/core/iweb_req_if.sv */
// ----------------------------------------------------------------------------
// iweb_req_if
// Request channel: valid/ready handshake with opcode and entry fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface iweb_req_if import iweb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           opcode;
  logic [PLD_W-1:0]          payload;
  logic signed [IMPIN_W-1:0] importance;
  logic [RIDX_W-1:0]         read_index;

  modport source (output valid, opcode, payload, importance, read_index, input ready);
  modport sink   (input valid, opcode, payload, importance, read_index, output ready);
endinterface

`default_nettype wire

/* rtl/core/iweb_rsp_if.sv */
// ----------------------------------------------------------------------------
// iweb_rsp_if
// Response channel: valid/ready handshake with read and status fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface iweb_rsp_if import iweb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PLD_W-1:0]   read_payload;
  logic [IMP_W-1:0]   read_importance;
  logic               read_valid;
  logic               evicted;
  logic [CNTO_W-1:0]  entry_count;
  logic [IMP_W-1:0]   min_importance;
  logic [IMP_W-1:0]   max_importance;
  logic [PLD_W-1:0]   newest_payload;

  modport source (output valid, read_payload, read_importance, read_valid, evicted,
                  entry_count, min_importance, max_importance, newest_payload,
                  input ready);
  modport sink   (input valid, read_payload, read_importance, read_valid, evicted,
                  entry_count, min_importance, max_importance, newest_payload,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/iweb_cfg.sv */
// ----------------------------------------------------------------------------
// iweb_cfg
// APB register block holding the capacity in use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iweb_cfg import iweb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CAP_W-1:0]      cap
);

  logic wr_cap;

  assign pready = 1'b1;
  assign wr_cap = psel && penable && pwrite && (paddr == CAP_ADDR);

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (wr_cap) begin
      cap <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr == CAP_ADDR) ? APB_DATA_W'(cap) : '0;

endmodule

`default_nettype wire

/* rtl/core/iweb_ctrl.sv */
// ----------------------------------------------------------------------------
// iweb_ctrl
// Sequencer: decodes a request and steps the datapath through the search,
// shift and append phases of an eviction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iweb_ctrl import iweb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  iweb_op_t    req_op,
  output logic        req_ready,
  input  iweb_sts_t   sts,
  output iweb_cmd_t   cmd
);

  iweb_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req_op == OP_PUSH) begin
            state_next = sts.full ? ST_SCAN : ST_APPEND;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (sts.last_issue) begin
          state_next = ST_SCAN_TAIL;
        end
      end
      ST_SCAN_TAIL:  state_next = ST_SHIFT;
      ST_SHIFT: begin
        if (sts.last_issue) begin
          state_next = ST_SHIFT_TAIL;
        end
      end
      ST_SHIFT_TAIL: state_next = ST_APPEND;
      ST_APPEND:     state_next = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.accept  = req_valid;
        cmd.pos_clr = req_valid;
      end
      ST_SCAN: begin
        cmd.issue     = 1'b1;
        cmd.proc_scan = 1'b1;
      end
      ST_SCAN_TAIL: begin
        cmd.proc_scan = 1'b1;
        cmd.pos_clr   = 1'b1;
        cmd.acc_init  = 1'b1;
      end
      ST_SHIFT: begin
        cmd.issue      = 1'b1;
        cmd.proc_shift = 1'b1;
      end
      ST_SHIFT_TAIL: cmd.proc_shift = 1'b1;
      ST_APPEND:     cmd.append     = 1'b1;
      ST_DONE:       cmd.load_out   = sts.out_free;
      default:       cmd            = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/iweb_dp.sv */
// ----------------------------------------------------------------------------
// iweb_dp
// Datapath: entry stores kept in age order, walk counter, victim search,
// min/max accumulators and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iweb_dp import iweb_pkg::*; #(
  parameter int MAX_ENTRIES  = DEF_MAX_ENTRIES,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CAP_W-1:0] cap,
  iweb_req_if.sink         req,
  iweb_rsp_if.source       rsp,
  input  iweb_cmd_t        cmd,
  output iweb_sts_t        sts
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int SB    = (PAYLOAD_BITS > PLD_W) ? PLD_W : PAYLOAD_BITS;
  localparam int HW    = CNT_W + RIDX_W;

  function automatic logic [IMP_W-1:0] imp_mag(input logic signed [IMPIN_W-1:0] v);
    logic [IMPIN_W-1:0] n;
    begin
      if (v[IMPIN_W-1]) begin
        n = $unsigned(~v) + {{(IMPIN_W-1){1'b0}}, 1'b1};
      end else begin
        n = $unsigned(v);
      end
      // most negative input saturates
      imp_mag = n[IMPIN_W-1] ? IMP_MAX : n[IMP_W-1:0];
    end
  endfunction

  // stores, position 0 is the oldest entry
  logic [IMP_W-1:0] imp_mem [MAX_ENTRIES];
  logic [SB-1:0]    pld_mem [MAX_ENTRIES];

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] eff_cap;
  logic [IDX_W-1:0] pos;
  logic             sv;
  logic [IDX_W-1:0] sv_pos;
  logic [IMP_W-1:0] rd_imp;
  logic [SB-1:0]    rd_pld;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IMP_W-1:0] wr_imp;
  logic [SB-1:0]    wr_pld;

  iweb_op_t         op;
  logic [IMP_W-1:0] new_imp;
  logic [SB-1:0]    new_pld;
  logic             full_hold;
  logic             hit;
  logic             evict_flag;
  logic [IMP_W-1:0] best;
  logic [IDX_W-1:0] victim;
  logic [IMP_W-1:0] min_imp;
  logic [IMP_W-1:0] max_imp;
  logic [SB-1:0]    newest;
  logic             out_valid;
  logic             shift_wr;
  logic             nonempty;

  // capacity in use, zero acts as one, clipped to the store depth
  always_comb begin
    if (cap == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(cap) > 32'(MAX_ENTRIES)) begin
      eff_cap = CNT_W'(MAX_ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap);
    end
  end

  assign sts.full       = (count >= eff_cap);
  assign sts.last_issue = (CNT_W'(pos) == CNT_W'(count - 1'b1));
  assign sts.out_free   = !out_valid || rsp.ready;

  // store ports
  assign rd_en    = (cmd.accept && (req.opcode == OP_READ)) || cmd.issue;
  assign rd_addr  = cmd.issue ? pos : IDX_W'(req.read_index);
  assign shift_wr = cmd.proc_shift && sv && (sv_pos > victim);
  assign wr_en    = cmd.append || shift_wr;
  assign wr_imp   = cmd.append ? new_imp : rd_imp;
  assign wr_pld   = cmd.append ? new_pld : rd_pld;

  always_comb begin
    if (cmd.append) begin
      wr_addr = full_hold ? IDX_W'(count - 1'b1) : IDX_W'(count);
    end else begin
      wr_addr = sv_pos - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      imp_mem[wr_addr] <= wr_imp;
      pld_mem[wr_addr] <= wr_pld;
    end
    if (rd_en) begin
      rd_imp <= imp_mem[rd_addr];
      rd_pld <= pld_mem[rd_addr];
    end
  end

  // walk position and read-return tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= 1'b0;
    end else begin
      sv <= cmd.issue;
    end
    sv_pos <= pos;
    if (cmd.pos_clr) begin
      pos <= '0;
    end else if (cmd.issue) begin
      pos <= pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept && (req.opcode == OP_CLEAR)) begin
      count <= '0;
    end else if (cmd.append && !full_hold) begin
      count <= CNT_W'(count + 1'b1);
    end
  end

  // request latch, victim search, min/max
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op         <= iweb_op_t'(req.opcode);
      new_imp    <= imp_mag(req.importance);
      new_pld    <= SB'(req.payload);
      full_hold  <= sts.full;
      hit        <= HW'(req.read_index) < HW'(count);
      evict_flag <= 1'b0;
      best       <= IMP_MAX;
      victim     <= '0;
    end else if (cmd.proc_scan && sv && (rd_imp < best)) begin
      // strict compare keeps the oldest on ties
      best   <= rd_imp;
      victim <= sv_pos;
    end else if (cmd.append) begin
      evict_flag <= full_hold;
    end

    if (cmd.acc_init) begin
      min_imp <= new_imp;
      max_imp <= new_imp;
    end else if (cmd.proc_shift && sv && (sv_pos != victim)) begin
      if (rd_imp < min_imp) min_imp <= rd_imp;
      if (rd_imp > max_imp) max_imp <= rd_imp;
    end else if (cmd.append) begin
      if (!full_hold && (count == '0)) begin
        min_imp <= new_imp;
        max_imp <= new_imp;
      end else begin
        if (new_imp < min_imp) min_imp <= new_imp;
        if (new_imp > max_imp) max_imp <= new_imp;
      end
    end

    if (cmd.append) begin
      newest <= new_pld;
    end
  end

  // output register
  assign nonempty = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.read_payload    <= ((op == OP_READ) && hit) ? PLD_W'(rd_pld) : '0;
      rsp.read_importance <= ((op == OP_READ) && hit) ? rd_imp : '0;
      rsp.read_valid      <= (op == OP_READ) && hit;
      rsp.evicted         <= (op == OP_PUSH) && evict_flag;
      rsp.entry_count     <= CNTO_W'(count);
      rsp.min_importance  <= nonempty ? min_imp : '0;
      rsp.max_importance  <= nonempty ? max_imp : '0;
      rsp.newest_payload  <= nonempty ? PLD_W'(newest) : '0;
    end
  end

  assign rsp.valid = out_valid;

endmodule

`default_nettype wire

/* rtl/core/importance_weighted_eviction_buffer_core.sv */
// ----------------------------------------------------------------------------
// importance_weighted_eviction_buffer_core
// A store of up to MAX_ENTRIES payload words kept oldest first, each with an
// unsigned Q7.8 importance (the magnitude of the pushed value, the most
// negative code saturating to the largest). Requests: push, read by age
// position, clear; each request returns exactly one response carrying the
// read fields plus count, min/max importance and newest payload. Once the
// count reaches the capacity register (zero acts as one), a push evicts the
// least important entry, oldest on ties. From accept to response, read,
// clear and no-op go straight to the response state; a push into free
// space appends first; an evicting push walks the single read port of the
// store once to find the victim and once to close the gap, then appends.
// One request is in flight at a time; a new one is taken while the previous
// response still waits in the output register.
// Capacity sits at APB byte address 0, reset value 16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module importance_weighted_eviction_buffer_core import iweb_pkg::*; #(
  parameter int MAX_ENTRIES  = DEF_MAX_ENTRIES,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // request / response channels
  iweb_req_if.sink              req,
  iweb_rsp_if.source            rsp
);

  logic [CAP_W-1:0] cap;
  iweb_cmd_t        cmd;
  iweb_sts_t        sts;
  logic             ctrl_ready;

  iweb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap     (cap)
  );

  // Sequencer: one request at a time, IDLE is the only state that takes one
  iweb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (iweb_op_t'(req.opcode)),
    .req_ready (ctrl_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  assign req.ready = ctrl_ready;

  // Stores, walk counter, search and the output register
  iweb_dp #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cap (cap),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

  // An accepted request holds off the next one in the following cycle
  `IWEB_ASSERT_NXT(a_one_in_flight, clk, rst, req.valid && req.ready, !req.ready)

  // Reported range is ordered
  `IWEB_ASSERT_IMP(a_min_le_max, clk, rst, rsp.valid,
                   rsp.min_importance <= rsp.max_importance)

  // An empty store reports no range and no newest word
  `IWEB_ASSERT_IMP(a_empty_status, clk, rst,
                   rsp.valid && (rsp.entry_count == '0) && (MAX_ENTRIES < 32),
                   (rsp.min_importance == '0) && (rsp.max_importance == '0) &&
                   (rsp.newest_payload == '0))

endmodule

`default_nettype wire
